// ===== hw/rtl/caf_pkg.sv =====
package caf_pkg;

	// Operation codes carried on s_tuser
	localparam logic [5:0] K_ADD    = 6'd0;
	localparam logic [5:0] K_ADC    = 6'd1;
	localparam logic [5:0] K_SUB    = 6'd2;
	localparam logic [5:0] K_SBC    = 6'd3;
	localparam logic [5:0] K_AND    = 6'd4;
	localparam logic [5:0] K_XOR    = 6'd5;
	localparam logic [5:0] K_OR     = 6'd6;
	localparam logic [5:0] K_CP     = 6'd7;
	localparam logic [5:0] K_INC    = 6'd8;
	localparam logic [5:0] K_DEC    = 6'd9;
	localparam logic [5:0] K_DAA    = 6'd10;
	localparam logic [5:0] K_CPL    = 6'd11;
	localparam logic [5:0] K_CCF    = 6'd12;
	localparam logic [5:0] K_SCF    = 6'd13;
	localparam logic [5:0] K_RLCA   = 6'd14;
	localparam logic [5:0] K_RRCA   = 6'd15;
	localparam logic [5:0] K_RLA    = 6'd16;
	localparam logic [5:0] K_RRA    = 6'd17;
	localparam logic [5:0] K_RLC    = 6'd18;
	localparam logic [5:0] K_RRC    = 6'd19;
	localparam logic [5:0] K_RL     = 6'd20;
	localparam logic [5:0] K_RR     = 6'd21;
	localparam logic [5:0] K_SLA    = 6'd22;
	localparam logic [5:0] K_SRA    = 6'd23;
	localparam logic [5:0] K_SWAP   = 6'd24;
	localparam logic [5:0] K_SRL    = 6'd25;
	localparam logic [5:0] K_BIT    = 6'd26;
	localparam logic [5:0] K_RES    = 6'd27;
	localparam logic [5:0] K_SET    = 6'd28;
	localparam logic [5:0] K_ADD16  = 6'd29;
	localparam logic [5:0] K_ADDSP  = 6'd30;
	localparam logic [5:0] K_INC16  = 6'd31;
	localparam logic [5:0] K_DEC16  = 6'd32;

	// DAA correction constants
	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_HI_CORR  = 8'h60;
	localparam logic [7:0] DAA_LO_CORR  = 8'h06;

	// Packed widths of the stream buses
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [7:0] acc;
		flags_t     flags;
	} state_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [7:0]  operand;
		logic [2:0]  bit_index;
		logic [15:0] word_base;
		logic [15:0] word_operand;
	} item_t;

	typedef struct packed {
		logic [7:0]  result_value;
		logic [15:0] word_result;
	} result_t;

endpackage

// ===== hw/rtl/caf_exec.sv =====
module caf_exec (
	input  caf_pkg::item_t   item,
	input  caf_pkg::state_t  cur,
	output caf_pkg::result_t res,
	output caf_pkg::state_t  nxt
);
	import caf_pkg::*;

	logic [7:0]  a;
	logic [7:0]  v;
	logic        ci;
	logic        ci_arith;
	logic [8:0]  add9;
	logic [4:0]  addh5;
	logic [8:0]  sub9;
	logic [4:0]  subh5;
	logic [7:0]  daa_corr;
	logic        daa_c;
	logic [7:0]  daa_a;
	logic [7:0]  bit_mask;
	logic [16:0] add16;
	logic [12:0] add16h;
	logic [15:0] sp_sum;
	logic [8:0]  sp_c9;
	logic [4:0]  sp_h5;
	logic [7:0]  shift_val;
	logic        shift_c;

	assign a  = cur.acc;
	assign v  = item.operand;
	assign ci = cur.flags.c;

	// Carry in only for ADC and SBC
	assign ci_arith = ((item.kind == K_ADC) || (item.kind == K_SBC)) ? ci : 1'b0;

	// Byte add and subtract with nibble carries
	assign add9  = {1'b0, a} + {1'b0, v} + {8'd0, ci_arith};
	assign addh5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci_arith};
	assign sub9  = {1'b0, a} - {1'b0, v} - {8'd0, ci_arith};
	assign subh5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci_arith};

	// Decimal adjust
	always_comb begin
		daa_corr = 8'd0;
		daa_c    = cur.flags.c;
		if (cur.flags.c || (!cur.flags.n && (a > DAA_HI_LIMIT))) begin
			daa_corr = daa_corr | DAA_HI_CORR;
			daa_c    = 1'b1;
		end
		if (cur.flags.h || (!cur.flags.n && (a[3:0] > DAA_LO_LIMIT))) begin
			daa_corr = daa_corr | DAA_LO_CORR;
		end
		daa_a = cur.flags.n ? (a - daa_corr) : (a + daa_corr);
	end

	assign bit_mask = 8'd1 << item.bit_index;

	// Word arithmetic
	assign add16  = {1'b0, item.word_base} + {1'b0, item.word_operand};
	assign add16h = {1'b0, item.word_base[11:0]} + {1'b0, item.word_operand[11:0]};
	assign sp_sum = item.word_base + {{8{v[7]}}, v};
	assign sp_c9  = {1'b0, item.word_base[7:0]} + {1'b0, v};
	assign sp_h5  = {1'b0, item.word_base[3:0]} + {1'b0, v[3:0]};

	// Prefixed rotates and shifts on the operand
	always_comb begin
		case (item.kind)
			K_RLC: begin
				shift_val = {v[6:0], v[7]};
				shift_c   = v[7];
			end
			K_RRC: begin
				shift_val = {v[0], v[7:1]};
				shift_c   = v[0];
			end
			K_RL: begin
				shift_val = {v[6:0], ci};
				shift_c   = v[7];
			end
			K_RR: begin
				shift_val = {ci, v[7:1]};
				shift_c   = v[0];
			end
			K_SLA: begin
				shift_val = {v[6:0], 1'b0};
				shift_c   = v[7];
			end
			K_SRA: begin
				shift_val = {v[7], v[7:1]};
				shift_c   = v[0];
			end
			K_SWAP: begin
				shift_val = {v[3:0], v[7:4]};
				shift_c   = 1'b0;
			end
			default: begin
				shift_val = {1'b0, v[7:1]};
				shift_c   = v[0];
			end
		endcase
	end

	// Select the outcome per operation
	always_comb begin
		nxt = cur;
		res = '0;
		case (item.kind)
			K_ADD, K_ADC: begin
				nxt.acc     = add9[7:0];
				nxt.flags.z = (add9[7:0] == 8'd0);
				nxt.flags.n = 1'b0;
				nxt.flags.h = addh5[4];
				nxt.flags.c = add9[8];
			end
			K_SUB, K_SBC, K_CP: begin
				if (item.kind != K_CP) begin
					nxt.acc = sub9[7:0];
				end
				nxt.flags.z = (sub9[7:0] == 8'd0);
				nxt.flags.n = 1'b1;
				nxt.flags.h = subh5[4];
				nxt.flags.c = sub9[8];
			end
			K_AND: begin
				nxt.acc   = a & v;
				nxt.flags = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			K_XOR: begin
				nxt.acc   = a ^ v;
				nxt.flags = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			K_OR: begin
				nxt.acc   = a | v;
				nxt.flags = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			K_INC: begin
				res.result_value = v + 8'd1;
				nxt.flags.z      = (v == 8'hFF);
				nxt.flags.n      = 1'b0;
				nxt.flags.h      = (v[3:0] == 4'hF);
			end
			K_DEC: begin
				res.result_value = v - 8'd1;
				nxt.flags.z      = (v == 8'h01);
				nxt.flags.n      = 1'b1;
				nxt.flags.h      = (v[3:0] == 4'h0);
			end
			K_DAA: begin
				nxt.acc     = daa_a;
				nxt.flags.z = (daa_a == 8'd0);
				nxt.flags.h = 1'b0;
				nxt.flags.c = daa_c;
			end
			K_CPL: begin
				nxt.acc     = ~a;
				nxt.flags.n = 1'b1;
				nxt.flags.h = 1'b1;
			end
			K_CCF: begin
				nxt.flags.n = 1'b0;
				nxt.flags.h = 1'b0;
				nxt.flags.c = ~ci;
			end
			K_SCF: begin
				nxt.flags.n = 1'b0;
				nxt.flags.h = 1'b0;
				nxt.flags.c = 1'b1;
			end
			K_RLCA: begin
				nxt.acc   = {a[6:0], a[7]};
				nxt.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
			end
			K_RRCA: begin
				nxt.acc   = {a[0], a[7:1]};
				nxt.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
			end
			K_RLA: begin
				nxt.acc   = {a[6:0], ci};
				nxt.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
			end
			K_RRA: begin
				nxt.acc   = {ci, a[7:1]};
				nxt.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
			end
			K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SWAP, K_SRL: begin
				res.result_value = shift_val;
				nxt.flags = '{z: (shift_val == 8'd0), n: 1'b0, h: 1'b0, c: shift_c};
			end
			K_BIT: begin
				res.result_value = v;
				nxt.flags.z      = ((v & bit_mask) == 8'd0);
				nxt.flags.n      = 1'b0;
				nxt.flags.h      = 1'b1;
			end
			K_RES: begin
				res.result_value = v & ~bit_mask;
			end
			K_SET: begin
				res.result_value = v | bit_mask;
			end
			K_ADD16: begin
				res.word_result = add16[15:0];
				nxt.flags.n     = 1'b0;
				nxt.flags.h     = add16h[12];
				nxt.flags.c     = add16[16];
			end
			K_ADDSP: begin
				res.word_result = sp_sum;
				nxt.flags = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
			end
			K_INC16: begin
				res.word_result = item.word_base + 16'd1;
			end
			K_DEC16: begin
				res.word_result = item.word_base - 16'd1;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== hw/rtl/cpu_alu_and_flags.sv =====
// Path: stage one registers the input and the result register holds its outcome;
// a stalled output holds both. Throughput: one operation per cycle unless the
// output stalls; the accumulator and flag registers are read and written by a
// single pass through the ALU logic, which sets the rate.
// Reset: arst_n low clears the accumulator, all flags and both valid stages.
module cpu_alu_and_flags (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// operand[7:0], bit_index[10:8], word_base[26:11], word_operand[42:27], zero fill
	input  logic [caf_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind[5:0]
	input  logic [5:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_value[7:0], acc_value[15:8], word_result[31:16], flag_zero[32],
	// flag_subtract[33], flag_half[34], flag_carry[35], zero fill
	output logic [caf_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import caf_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	state_t  state_q;
	state_t  nxt_state;
	result_t exec_res;
	logic    valid_s2;
	result_t res_s2;
	state_t  post_s2;
	logic    s2_free;
	logic    advance;

	assign s2_free  = !valid_s2 || m_tready;
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// Capture an input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= s_tuser;
			item_s1.operand      <= s_tdata[7:0];
			item_s1.bit_index    <= s_tdata[10:8];
			item_s1.word_base    <= s_tdata[26:11];
			item_s1.word_operand <= s_tdata[42:27];
		end
	end

	caf_exec u_exec (
		.item (item_s1),
		.cur  (state_q),
		.res  (exec_res),
		.nxt  (nxt_state)
	);

	// Commit accumulator and flags as the operation leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= nxt_state;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= exec_res;
			post_s2 <= nxt_state;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, post_s2.flags.c, post_s2.flags.h, post_s2.flags.n,
		post_s2.flags.z, res_s2.word_result, post_s2.acc, res_s2.result_value};

endmodule

// ===== hw/rtl/caf_checker.sv =====
module caf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [caf_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [5:0]                     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [caf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import caf_pkg::*;

	// Hold an offered transaction until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}))
		else $error("offered input changed before acceptance");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

	// Backpressure input only while the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// No result while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result shown during reset");

	// Padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:36] == '0))
		else $error("output padding not zero");

endmodule

bind cpu_alu_and_flags caf_checker u_caf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
